>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; compile first.
package spq_pkg;

   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 16;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [PAYLOAD_W-1:0] payload_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the request beat
      logic exec;   // apply the captured operation, write the response register
   } cmd_type;

endpackage

>>> rtl/core/spq_channels.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on spq_pkg.
interface spq_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   spq_pkg::key_type     key;
   spq_pkg::payload_type payload;

   modport source (output valid, output mode, output key, output payload, input ready);
   modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

interface spq_rsp_if;
   logic                 valid;
   logic                 ready;
   spq_pkg::key_type     out_key;
   spq_pkg::payload_type out_payload;
   spq_pkg::status_type  status;
   spq_pkg::count_type   count;

   modport source (output valid, output out_key, output out_payload, output status,
                   output count, input ready);
   modport sink   (input valid, input out_key, input out_payload, input status,
                   input count, output ready);
endinterface

>>> rtl/core/spq_ctrl.sv
// Handshake controller: request capture, execute step, response valid.
// Depends on spq_pkg.
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic exec, load;

   assign exec      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) || exec;
   assign load      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = load;
   assign cmd.exec  = exec;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (load)      state_in = S_EXEC;
            else if (exec) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (exec)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/spq_datapath.sv
// Sorted entry cells, operation register, response register and order register.
// Depends on spq_pkg.
module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::cmd_type     cmd,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 in_mode,
   input  spq_pkg::key_type     in_key,
   input  spq_pkg::payload_type in_payload,
   output spq_pkg::key_type     out_key,
   output spq_pkg::payload_type out_payload,
   output spq_pkg::status_type  out_status,
   output spq_pkg::count_type   out_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic                 larger_first_ff;
   logic                 op_mode_ff;
   spq_pkg::key_type     op_key_ff;
   spq_pkg::payload_type op_payload_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   spq_pkg::key_type     key_ff     [DEPTH];
   spq_pkg::payload_type payload_ff [DEPTH];

   spq_pkg::key_type     rsp_key_ff, rsp_key_in;
   spq_pkg::payload_type rsp_payload_ff, rsp_payload_in;
   spq_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic [DEPTH-1:0] hit;           // new key outranks the cell, or the cell is empty
   logic [DEPTH-1:0] at_or_after;   // cell sits at or behind the insert slot
   logic [DEPTH-1:0] prev_after;
   logic             full, empty, do_push, do_pop;
   logic [CNT_W+4:0] count_ext;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = cmd.exec && (op_mode_ff == spq_pkg::MODE_PUSH) && !full;
   assign do_pop  = cmd.exec && (op_mode_ff == spq_pkg::MODE_POP) && !empty;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                 held;
         logic                 outranks;
         spq_pkg::key_type     shift_key, next_key;
         spq_pkg::payload_type shift_payload, next_payload;

         assign held     = CNT_W'(i) < count_ff;
         assign outranks = larger_first_ff ? (op_key_ff > key_ff[i]) : (op_key_ff < key_ff[i]);
         assign hit[i]   = !held || outranks;
         // first hit marks the slot, even if the order changed while entries are held
         assign at_or_after[i] = |hit[i:0];

         if (i == 0) begin : g_head
            assign prev_after[i]  = 1'b0;
            assign shift_key      = op_key_ff;
            assign shift_payload  = op_payload_ff;
         end else begin : g_body
            assign prev_after[i]  = at_or_after[i-1];
            assign shift_key      = key_ff[i-1];
            assign shift_payload  = payload_ff[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign next_key     = key_ff[i];
            assign next_payload = payload_ff[i];
         end else begin : g_mid
            assign next_key     = key_ff[i+1];
            assign next_payload = payload_ff[i+1];
         end

         always_ff @(posedge clock) begin
            if (do_push && at_or_after[i]) begin
               if (prev_after[i]) begin
                  key_ff[i]     <= shift_key;
                  payload_ff[i] <= shift_payload;
               end else begin
                  key_ff[i]     <= op_key_ff;
                  payload_ff[i] <= op_payload_ff;
               end
            end else if (do_pop) begin
               key_ff[i]     <= next_key;
               payload_ff[i] <= next_payload;
            end
         end
      end
   endgenerate

   always_comb begin
      count_in       = count_ff;
      rsp_key_in     = '0;
      rsp_payload_in = '0;
      rsp_status_in  = spq_pkg::STATUS_DONE;
      if (op_mode_ff == spq_pkg::MODE_PUSH) begin
         if (full) rsp_status_in = spq_pkg::STATUS_FULL;
         else      count_in      = count_ff + CNT_W'(1);
      end else begin
         if (empty) begin
            rsp_status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            rsp_key_in     = key_ff[0];
            rsp_payload_in = payload_ff[0];
            count_in       = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         larger_first_ff <= 1'b1;
      end else begin
         if (cmd.exec) count_ff <= count_in;
         if (csr_wr_en) larger_first_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_mode_ff    <= in_mode;
         op_key_ff     <= in_key;
         op_payload_ff <= in_payload;
      end
      if (cmd.exec) begin
         rsp_key_ff     <= rsp_key_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign count_ext   = {5'd0, count_ff};
   assign out_key     = rsp_key_ff;
   assign out_payload = rsp_payload_ff;
   assign out_status  = rsp_status_ff;
   assign out_count   = count_ext[4:0];

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted-array priority queue, top level.
// Depends on spq_pkg, spq_channels, spq_ctrl and spq_datapath.
//
// Usage:
//   req_ch carries one operation per beat: mode 0 pushes (key, payload),
//   mode 1 pops the front entry. rsp_ch returns one beat per request with
//   the popped key and payload (zero otherwise), a status code (done, pop
//   on empty, push on full dropped) and the entry count afterwards.
//   csr_wr_en/csr_wr_data set the order: 1 larger key first, 0 smaller key
//   first. Write it only while no request is in flight.
// Timing:
//   A request is captured on acceptance and applied in the execute step,
//   when every cell compares its key with the new one and shifts in one step.
//   Response valid rises as the execute step writes the response register; one item per
//   cycle is sustained while the response side keeps taking beats.
//   The response register holds one finished beat; a stalled receiver
//   holds the next request in the capture register and then backs up req_ch.
// Reset:
//   Synchronous, active high. Empties the queue and sets larger key first.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_mode     (req_ch.mode),
      .in_key      (req_ch.key),
      .in_payload  (req_ch.payload),
      .out_key     (rsp_ch.out_key),
      .out_payload (rsp_ch.out_payload),
      .out_status  (rsp_ch.status),
      .out_count   (rsp_ch.count)
   );

endmodule

>>> test/testbench.sv
// Self-checking testbench for sorted_priority_queue: push/pop beats are scored
// against a queue-based predictor kept inside the bench.
// Depends on spq_pkg, spq_channels and the sorted_priority_queue RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 26;
   localparam int PHASE_ITEMS = 315;

   typedef struct {
      spq_pkg::key_type     out_key;
      spq_pkg::payload_type out_payload;
      spq_pkg::status_type  status;
      spq_pkg::count_type   count;
   } rsp_beat_type;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic csr_wr_en   = 1'b0;
   logic csr_wr_data = 1'b0;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   spq_pkg::key_type     model_keys[$];
   spq_pkg::payload_type model_payloads[$];
   logic                 model_larger_first = 1'b1;
   rsp_beat_type         pending_rsps[$];
   int                   fail_count  = 0;
   int                   cycle_count = 0;
   bit                   send_gaps_on  = 1'b1;
   bit                   rsp_stalls_on = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit outranks_key(spq_pkg::key_type a, spq_pkg::key_type b);
      return model_larger_first ? (a > b) : (a < b);
   endfunction

   // Applies one operation to the model queue and returns the beat it yields.
   function automatic rsp_beat_type apply_queue_op(logic mode, spq_pkg::key_type key,
                                                   spq_pkg::payload_type payload);
      rsp_beat_type beat;
      int           pos;
      beat = '{default: '0};
      if (mode == spq_pkg::MODE_PUSH) begin
         if (model_keys.size() >= QUEUE_DEPTH) begin
            beat.status = spq_pkg::STATUS_FULL;
         end else begin
            pos = model_keys.size();
            for (int i = 0; i < model_keys.size(); i++) begin
               if (outranks_key(key, model_keys[i])) begin
                  pos = i;
                  break;
               end
            end
            model_keys.insert(pos, key);
            model_payloads.insert(pos, payload);
            beat.status = spq_pkg::STATUS_DONE;
         end
      end else if (model_keys.size() == 0) begin
         beat.status = spq_pkg::STATUS_EMPTY;
      end else begin
         beat.out_key     = model_keys.pop_front();
         beat.out_payload = model_payloads.pop_front();
         beat.status      = spq_pkg::STATUS_DONE;
      end
      beat.count = spq_pkg::count_type'(model_keys.size());
      return beat;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ch.ready <= !rsp_stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            $display({"%0t: unexpected rsp beat: expected none ",
                      "actual key %h payload %h st %0d cnt %0d"},
                     $time, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.status,
                     rsp_ch.count);
            fail_count++;
         end else begin
            want = pending_rsps.pop_front();
            check_field("out_key", want.out_key, rsp_ch.out_key);
            check_field("out_payload", want.out_payload, rsp_ch.out_payload);
            check_field("status", 16'(want.status), 16'(rsp_ch.status));
            check_field("count", 16'(want.count), 16'(rsp_ch.count));
         end
      end
   end

   task automatic send_op(logic mode, spq_pkg::key_type key, spq_pkg::payload_type payload);
      while (send_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= mode;
      req_ch.key     <= key;
      req_ch.payload <= payload;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_rsps.push_back(apply_queue_op(mode, key, payload));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   task automatic write_order(logic larger);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= larger;
      @(posedge clock);
      csr_wr_en          <= 1'b0;
      model_larger_first = larger;
   endtask

   task automatic test_pop_empty();
      send_op(spq_pkg::MODE_POP, '1, '1);
   endtask

   // fills the queue with corner keys and repeated keys to exercise tie order
   task automatic test_fill_with_ties();
      spq_pkg::key_type fill_keys[QUEUE_DEPTH] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h8000,
                                                   16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE,
                                                   16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5,
                                                   16'h5A5A, 16'h8000, 16'h0100, 16'hFFFF};
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_op(spq_pkg::MODE_PUSH, fill_keys[i], spq_pkg::payload_type'(i * 16'h1111));
      end
   endtask

   task automatic test_push_when_full();
      send_op(spq_pkg::MODE_PUSH, '1, '1);
      send_op(spq_pkg::MODE_PUSH, '0, '0);
      drain_results();
   endtask

   task automatic test_pop_order();
      for (int i = 0; i < 5; i++) begin
         send_op(spq_pkg::MODE_POP, spq_pkg::key_type'($urandom),
                 spq_pkg::payload_type'($urandom));
      end
   endtask

   task automatic run_random_phase(int n_items);
      spq_pkg::key_type corner_keys[4] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
      int               sent;
      int               burst;
      int               push_pct;
      int               key_style;
      logic             mode;
      spq_pkg::key_type key;
      sent = 0;
      while (sent < n_items) begin
         burst     = $urandom_range(1, 24);
         key_style = $urandom_range(0, 3);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 20;
            default: push_pct = 55;
         endcase
         for (int i = 0; i < burst && sent < n_items; i++) begin
            mode = ($urandom_range(0, 99) < push_pct) ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP;
            case (key_style)
               0: key = spq_pkg::key_type'($urandom_range(0, 3));
               1: key = corner_keys[$urandom_range(0, 3)];
               default: key = spq_pkg::key_type'($urandom_range(0, 16'hFFFF));
            endcase
            send_op(mode, key, spq_pkg::payload_type'($urandom_range(0, 16'hFFFF)));
            sent++;
         end
         if ($urandom_range(0, 39) == 0) begin
            drain_results();
         end
      end
   endtask

   // order setting per phase; phase 2 runs with no idling on either side
   task automatic test_random_traffic();
      logic phase_order[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int p = 0; p < 6; p++) begin
         write_order(phase_order[p]);
         send_gaps_on  = (p != 2);
         rsp_stalls_on = (p != 2);
         run_random_phase(PHASE_ITEMS);
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.mode    = spq_pkg::MODE_PUSH;
      req_ch.key     = '0;
      req_ch.payload = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_pop_empty();
      test_fill_with_ties();
      test_push_when_full();
      test_pop_order();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_channels.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue.sv
test/testbench.sv
